/* design/lfu_pkg.sv */
// Shared types and constants for the LFU slot replacement block.
// Used by lfu_store, lfu_scan and lfu_slot_replacement; depends on nothing.
`default_nettype none

package lfu_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 16;
  localparam int COUNT_W  = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int OCC_W    = $clog2(SLOTS + 1);
  localparam int LIMIT_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [SLOT_W-1:0]   rank_t;

  // One slot as read back from the store, registered in the cycle after its address.
  typedef struct packed {
    logic   strobe;
    logic   valid;
    slot_t  idx;
    key_t   key;
    count_t count;
    rank_t  rank;
  } rd_beat_t;

  // Write-back command from the sequencer to the store.
  typedef struct packed {
    logic   key_we;
    logic   count_we;
    logic   rank_we;
    logic   set_valid;
    logic   age_shift;
    slot_t  idx;
    key_t   key;
    count_t count;
    rank_t  rank;
    rank_t  age_ref;
  } wr_cmd_t;

  // Outcome of one pass over the slots.
  typedef struct packed {
    logic   found;
    slot_t  hit_idx;
    count_t hit_count;
    logic   free_any;
    slot_t  free_idx;
    logic   vic_any;
    slot_t  vic_idx;
    key_t   vic_key;
    count_t vic_count;
    rank_t  vic_rank;
  } scan_res_t;

endpackage

`default_nettype wire

/* design/lfu_slot_replacement.sv */
// Top level: command interface, sequencer and write-back decision of the LFU slot table.
// Depends on lfu_pkg, lfu_store and lfu_scan.
//
//  port group   direction  beat marked by        contents
//  command      in         start & !busy         key
//  result       out        done (one cycle)      hit, slot_index, evicted, evicted_key, use_count
//  config       in         cfg_we                cfg_wdata = slots_in_use
//
// Each key goes from acceptance to write-back through a scan state of 16 reads through the
// key/count memory port, a drain state for the last registered read, and a commit state.
// The result is shown on the cycle after the commit, when busy is already low again.
// Synchronous reset invalidates every slot, clears occupancy and sets slots_in_use to 16.
// The result port cannot be held off; each result is marked by done for exactly one cycle.
`default_nettype none

module lfu_slot_replacement
  import lfu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [KEY_BITS-1:0] key,
  output logic                     busy,
  output logic                     done,
  output logic                     hit,
  output logic [SLOT_W-1:0]        slot_index,
  output logic                     evicted,
  output logic [KEY_BITS-1:0]      evicted_key,
  output logic [COUNT_W-1:0]       use_count,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  slot_t            cnt;
  key_t             key_q;
  logic [LIMIT_W-1:0] limit;
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] eff_limit;
  logic             accept;
  logic             do_hit;
  logic             do_free;
  logic             do_evict;
  count_t           hit_count_next;
  rd_beat_t         rd;
  wr_cmd_t          wr;
  scan_res_t        res;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  lfu_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (state == ST_SCAN),
    .rd_idx (cnt),
    .wr     (wr),
    .rd     (rd)
  );

  lfu_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .clear (accept),
    .key   (key_q),
    .rd    (rd),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // A limit of zero behaves as one and anything above the table size as the table size.
  always_comb begin
    if (limit == '0) begin
      eff_limit = OCC_W'(1);
    end else if (OCC_W'(limit) > OCC_W'(SLOTS)) begin
      eff_limit = OCC_W'(SLOTS);
    end else begin
      eff_limit = OCC_W'(limit);
    end
  end

  assign do_hit   = res.found;
  assign do_free  = !res.found && occupancy < eff_limit && res.free_any;
  assign do_evict = !res.found && !do_free && res.vic_any;
  assign hit_count_next = (res.hit_count == COUNT_MAX) ? COUNT_MAX
                                                       : res.hit_count + COUNT_ONE;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == slot_t'(SLOTS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        cnt <= cnt + slot_t'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= key;
    end
  end

  always_comb begin
    wr = '0;
    wr.key   = key_q;
    wr.count = COUNT_ONE;
    if (state == ST_COMMIT) begin
      if (do_hit) begin
        wr.count_we = 1'b1;
        wr.idx      = res.hit_idx;
        wr.count    = hit_count_next;
      end else if (do_free) begin
        wr.key_we    = 1'b1;
        wr.count_we  = 1'b1;
        wr.rank_we   = 1'b1;
        wr.set_valid = 1'b1;
        wr.idx       = res.free_idx;
        wr.rank      = rank_t'(occupancy);
      end else if (do_evict) begin
        wr.key_we    = 1'b1;
        wr.count_we  = 1'b1;
        wr.rank_we   = 1'b1;
        wr.age_shift = 1'b1;
        wr.idx       = res.vic_idx;
        wr.rank      = rank_t'(occupancy - OCC_W'(1));
        wr.age_ref   = res.vic_rank;
      end else begin
        // Empty table with no free slot cannot occur; restart from slot zero if it does.
        wr.key_we    = 1'b1;
        wr.count_we  = 1'b1;
        wr.rank_we   = 1'b1;
        wr.set_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      done <= state == ST_COMMIT;
      if (state == ST_COMMIT) begin
        if (do_free) begin
          occupancy <= occupancy + OCC_W'(1);
        end else if (!do_hit && !do_evict) begin
          occupancy <= OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMMIT) begin
      hit         <= do_hit;
      slot_index  <= wr.idx;
      evicted     <= do_evict;
      evicted_key <= do_evict ? res.vic_key : '0;
      use_count   <= wr.count;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_COMMIT)
    else $error("result beat without a commit");

  assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(SLOTS))
    else $error("occupancy beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted) && (evicted || evicted_key == '0) && use_count != '0)
    else $error("inconsistent result beat");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT && do_free |-> occupancy < OCC_W'(SLOTS))
    else $error("insertion into a full table");

endmodule

`default_nettype wire

/* design/lfu_store.sv */
// Slot storage: key and count memories with registered reads, valid flags and age ranks.
// Depends on lfu_pkg.
`default_nettype none

module lfu_store
  import lfu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     rd_en,
  input  wire slot_t    rd_idx,
  input  wire wr_cmd_t  wr,
  output rd_beat_t      rd
);

  key_t   key_mem   [SLOTS];
  count_t count_mem [SLOTS];
  logic [SLOTS-1:0] valid;
  rank_t  rank [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.idx] <= wr.key;
    end
    if (wr.count_we) begin
      count_mem[wr.idx] <= wr.count;
    end
    rd.key   <= key_mem[rd_idx];
    rd.count <= count_mem[rd_idx];
    rd.valid <= valid[rd_idx];
    rd.rank  <= rank[rd_idx];
    rd.idx   <= rd_idx;
    if (rst) begin
      rd.strobe <= 1'b0;
    end else begin
      rd.strobe <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.set_valid) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // On an eviction every younger entry moves up one rank, so ranks stay dense.
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (wr.rank_we && wr.idx == slot_t'(i)) begin
        rank[i] <= wr.rank;
      end else if (wr.age_shift && valid[i] && rank[i] > wr.age_ref) begin
        rank[i] <= rank[i] - rank_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/lfu_scan.sv */
// Shared compare unit: takes one slot per beat and tracks the match, first free slot and victim.
// Depends on lfu_pkg.
`default_nettype none

module lfu_scan
  import lfu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     clear,
  input  wire key_t     key,
  input  wire rd_beat_t rd,
  output scan_res_t     res
);

  logic better;

  // Lower count wins; on equal counts the older insertion wins.
  assign better = !res.vic_any || rd.count < res.vic_count ||
                  (rd.count == res.vic_count && rd.rank < res.vic_rank);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.found    <= 1'b0;
      res.free_any <= 1'b0;
      res.vic_any  <= 1'b0;
    end else if (rd.strobe) begin
      if (rd.valid) begin
        if (!res.found && rd.key == key) begin
          res.found     <= 1'b1;
          res.hit_idx   <= rd.idx;
          res.hit_count <= rd.count;
        end
        if (better) begin
          res.vic_any   <= 1'b1;
          res.vic_idx   <= rd.idx;
          res.vic_key   <= rd.key;
          res.vic_count <= rd.count;
          res.vic_rank  <= rd.rank;
        end
      end else if (!res.free_any) begin
        res.free_any <= 1'b1;
        res.free_idx <= rd.idx;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    rd.strobe && !rd.valid |=> res.free_any)
    else $error("free slot seen but not recorded");

  assert property (@(posedge clk) disable iff (rst)
    rd.strobe && rd.valid && !clear |=> res.vic_any)
    else $error("valid slot seen but no victim recorded");

  assert property (@(posedge clk) disable iff (rst)
    res.found && !clear && !$past(clear) |=> res.found && $stable(res.hit_idx))
    else $error("hit slot changed after first match");

endmodule

`default_nettype wire
